// ----- hw/rtl/tpv_pkg.sv -----
package tpv_pkg;

  localparam int unsigned PC_W = 5;
  localparam int unsigned ACC_W = 48;
  localparam int unsigned PROD_W = 37;
  localparam int unsigned PADDR_W = 5;

  localparam logic signed [15:0] DESIRED_LATERAL_DEF = 16'sd0;
  localparam logic signed [15:0] INTEG_LIM = 16'sd25600;
  localparam logic signed [9:0] VEL_LIM = 10'sd384;
  localparam logic signed [17:0] K_POINT3 = 18'sd1229;
  localparam logic signed [17:0] K_NEG3 = -18'sd1229;

  localparam logic [15:0] RST_GAIN_FWD_P = 16'd2458;
  localparam logic [15:0] RST_GAIN_FWD_I = 16'd0;
  localparam logic [15:0] RST_GAIN_FWD_D = 16'd41;
  localparam logic [15:0] RST_GAIN_VERT_P = 16'd2458;
  localparam logic [15:0] RST_GAIN_VERT_I = 16'd0;
  localparam logic [15:0] RST_GAIN_VERT_D = 16'd41;
  localparam logic [15:0] RST_DESIRED_DISTANCE = 16'd1664;
  localparam logic [15:0] RST_DESIRED_HEIGHT = 16'd0;

  localparam logic [PC_W-1:0] STEP_WAIT = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_PUSH = PC_W'(17);
  localparam logic [PC_W-1:0] STEP_LAST = PC_W'(17);

  typedef enum logic [2:0] {
    REG_GAIN_FWD_P,
    REG_GAIN_FWD_I,
    REG_GAIN_FWD_D,
    REG_GAIN_VERT_P,
    REG_GAIN_VERT_I,
    REG_GAIN_VERT_D,
    REG_DESIRED_DISTANCE,
    REG_DESIRED_HEIGHT
  } reg_e;

  typedef enum logic [1:0] {COND_NONE, COND_NO_INPUT, COND_OUT_BUSY} cond_e;
  typedef enum logic [1:0] {AX_FWD, AX_LAT, AX_VERT} axis_e;
  typedef enum logic [2:0] {A_ERR, A_DER, A_INT, A_X, A_ACC_LO, A_ACC_HI} a_sel_e;
  typedef enum logic [2:0] {B_GP, B_GI, B_GD, B_K3, B_NK3} b_sel_e;
  typedef enum logic [1:0] {ACC_NOP, ACC_LOAD, ACC_ADD, ACC_ADDSH} acc_op_e;
  typedef enum logic [1:0] {WB_NONE, WB_FWD, WB_YAW, WB_LAT} wb_e;

  typedef struct packed {
    logic            take;
    logic            push;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            loop_en;
    axis_e           axis;
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    acc_op_e         acc_op;
    wb_e             wb;
  } ctrl_t;

  typedef struct packed {
    logic signed [15:0] gain_fwd_p;
    logic signed [15:0] gain_fwd_i;
    logic signed [15:0] gain_fwd_d;
    logic signed [15:0] gain_vert_p;
    logic signed [15:0] gain_vert_i;
    logic signed [15:0] gain_vert_d;
    logic signed [15:0] desired_distance;
    logic signed [15:0] desired_height;
  } cfg_t;

  function automatic ctrl_t tpv_prog(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    unique case (pc)
      5'd0: begin
        c.take = 1'b1;
        c.cond = COND_NO_INPUT;
        c.target = STEP_WAIT;
      end
      5'd1: begin
        c.loop_en = 1'b1;
        c.axis = AX_FWD;
      end
      5'd2: begin
        c.a_sel = A_ERR;
        c.b_sel = B_GP;
      end
      5'd3: begin
        c.a_sel = A_DER;
        c.b_sel = B_GD;
        c.acc_op = ACC_LOAD;
      end
      5'd4: begin
        c.a_sel = A_INT;
        c.b_sel = B_GI;
        c.acc_op = ACC_ADD;
      end
      5'd5: begin
        c.a_sel = A_X;
        c.b_sel = B_NK3;
        c.acc_op = ACC_ADD;
      end
      5'd6: begin
        c.wb = WB_FWD;
        c.acc_op = ACC_LOAD;
        c.loop_en = 1'b1;
        c.axis = AX_LAT;
      end
      5'd7: begin
        c.wb = WB_YAW;
        c.a_sel = A_ERR;
        c.b_sel = B_GP;
      end
      5'd8: begin
        c.a_sel = A_DER;
        c.b_sel = B_GD;
        c.acc_op = ACC_LOAD;
      end
      5'd9: begin
        c.a_sel = A_INT;
        c.b_sel = B_GI;
        c.acc_op = ACC_ADD;
      end
      5'd10: begin
        c.acc_op = ACC_ADD;
      end
      5'd11: begin
        c.a_sel = A_ACC_LO;
        c.b_sel = B_K3;
      end
      5'd12: begin
        c.a_sel = A_ACC_HI;
        c.b_sel = B_K3;
        c.acc_op = ACC_LOAD;
        c.loop_en = 1'b1;
        c.axis = AX_VERT;
      end
      5'd13: begin
        c.a_sel = A_ERR;
        c.b_sel = B_GP;
        c.acc_op = ACC_ADDSH;
      end
      5'd14: begin
        c.wb = WB_LAT;
        c.a_sel = A_DER;
        c.b_sel = B_GD;
        c.acc_op = ACC_LOAD;
      end
      5'd15: begin
        c.a_sel = A_INT;
        c.b_sel = B_GI;
        c.acc_op = ACC_ADD;
      end
      5'd16: begin
        c.acc_op = ACC_ADD;
      end
      5'd17: begin
        c.push = 1'b1;
        c.cond = COND_OUT_BUSY;
        c.target = STEP_PUSH;
      end
      default: begin
        c.cond = COND_NONE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/tpv_in_if.sv -----
interface tpv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] target_z;

  modport source (output valid, output target_x, output target_y, output target_z,
                  input ready);
  modport sink (input valid, input target_x, input target_y, input target_z,
                output ready);
endinterface

// ----- hw/rtl/tpv_out_if.sv -----
interface tpv_out_if;
  logic               valid;
  logic               ready;
  logic signed [9:0]  forward_vel;
  logic signed [15:0] yaw_rate;
  logic signed [15:0] vertical_vel;
  logic signed [9:0]  lateral_vel;

  modport source (output valid, output forward_vel, output yaw_rate, output vertical_vel,
                  output lateral_vel, input ready);
  modport sink (input valid, input forward_vel, input yaw_rate, input vertical_vel,
                input lateral_vel, output ready);
endinterface

// ----- hw/rtl/three_axis_pid_velocity_top.sv -----
// An accepted word runs through the 18-step control program; a new word is taken
// only back at its wait step. All three loops share a single 19x18 multiplier and
// accumulator; the push step holds while the output is still occupied.
// Reset clears the loop integrals, previous errors, step counter and output valid,
// and loads the configuration registers with their default gains and setpoints.
module three_axis_pid_velocity_top #(
  parameter logic signed [15:0] DESIRED_LATERAL = tpv_pkg::DESIRED_LATERAL_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tpv_in_if.sink                       in_i,
  tpv_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpv_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tpv_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  out_busy;

  tpv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpv_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  tpv_dp #(
    .DESIRED_LATERAL (DESIRED_LATERAL)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .ctrl_i     (ctrl),
    .in_i       (in_i),
    .out_o      (out_o),
    .out_busy_o (out_busy)
  );

  a_no_back_to_back_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("word accepted while the previous one is still in work");

  a_out_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(ctrl.push))
    else $error("output valid raised outside the push step");

  a_push_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.push && out_busy) |=> ctrl.push)
    else $error("push step left while the output was still occupied");

  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.forward_vel >= -10'sd384 && out_o.forward_vel <= 10'sd384 &&
                     out_o.lateral_vel >= -10'sd384 && out_o.lateral_vel <= 10'sd384))
    else $error("velocity output outside its clamp range");

endmodule

// ----- hw/rtl/tpv_cfg.sv -----
module tpv_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpv_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output tpv_pkg::cfg_t                 cfg_o
);
  import tpv_pkg::*;

  cfg_t cfg_q;
  reg_e idx;
  logic wr_en;

  assign idx = reg_e'(paddr[4:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_fwd_p <= RST_GAIN_FWD_P;
      cfg_q.gain_fwd_i <= RST_GAIN_FWD_I;
      cfg_q.gain_fwd_d <= RST_GAIN_FWD_D;
      cfg_q.gain_vert_p <= RST_GAIN_VERT_P;
      cfg_q.gain_vert_i <= RST_GAIN_VERT_I;
      cfg_q.gain_vert_d <= RST_GAIN_VERT_D;
      cfg_q.desired_distance <= RST_DESIRED_DISTANCE;
      cfg_q.desired_height <= RST_DESIRED_HEIGHT;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_FWD_P: cfg_q.gain_fwd_p <= pwdata[15:0];
        REG_GAIN_FWD_I: cfg_q.gain_fwd_i <= pwdata[15:0];
        REG_GAIN_FWD_D: cfg_q.gain_fwd_d <= pwdata[15:0];
        REG_GAIN_VERT_P: cfg_q.gain_vert_p <= pwdata[15:0];
        REG_GAIN_VERT_I: cfg_q.gain_vert_i <= pwdata[15:0];
        REG_GAIN_VERT_D: cfg_q.gain_vert_d <= pwdata[15:0];
        REG_DESIRED_DISTANCE: cfg_q.desired_distance <= pwdata[15:0];
        REG_DESIRED_HEIGHT: cfg_q.desired_height <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_FWD_P: prdata = {16'b0, cfg_q.gain_fwd_p};
      REG_GAIN_FWD_I: prdata = {16'b0, cfg_q.gain_fwd_i};
      REG_GAIN_FWD_D: prdata = {16'b0, cfg_q.gain_fwd_d};
      REG_GAIN_VERT_P: prdata = {16'b0, cfg_q.gain_vert_p};
      REG_GAIN_VERT_I: prdata = {16'b0, cfg_q.gain_vert_i};
      REG_GAIN_VERT_D: prdata = {16'b0, cfg_q.gain_vert_d};
      REG_DESIRED_DISTANCE: prdata = {16'b0, cfg_q.desired_distance};
      REG_DESIRED_HEIGHT: prdata = {16'b0, cfg_q.desired_height};
    endcase
  end

endmodule

// ----- hw/rtl/tpv_seq.sv -----
module tpv_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_busy_i,
  output tpv_pkg::ctrl_t  ctrl_o
);
  import tpv_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  logic            jump;

  assign ctrl_o = tpv_prog(pc_q);

  always_comb begin
    unique case (ctrl_o.cond)
      COND_NONE: jump = 1'b0;
      COND_NO_INPUT: jump = ~in_valid_i;
      COND_OUT_BUSY: jump = out_busy_i;
      default: jump = 1'b0;
    endcase
    if (jump) begin
      pc_d = ctrl_o.target;
    end else if (pc_q == STEP_LAST) begin
      pc_d = STEP_WAIT;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- hw/rtl/tpv_dp.sv -----
module tpv_dp #(
  parameter logic signed [15:0] DESIRED_LATERAL = tpv_pkg::DESIRED_LATERAL_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tpv_pkg::cfg_t   cfg_i,
  input  tpv_pkg::ctrl_t  ctrl_i,
  tpv_in_if.sink          in_i,
  tpv_out_if.source       out_o,
  output logic            out_busy_o
);
  import tpv_pkg::*;

  localparam logic signed [ACC_W-1:0] YAW_OFF =
    {{(ACC_W-28){DESIRED_LATERAL[15]}}, DESIRED_LATERAL, 12'b0};
  localparam logic signed [ACC_W-1:0] HALF_12 = ACC_W'(2048);
  localparam logic signed [ACC_W-1:0] HALF_24 = ACC_W'(8388608);

  logic signed [15:0] x_q, y_q, z_q;
  logic signed [15:0] fwd_integ_q, lat_integ_q, vert_integ_q;
  logic signed [16:0] fwd_prev_q, lat_prev_q, vert_prev_q;
  logic signed [16:0] err_q;
  logic signed [17:0] der_q;
  logic signed [15:0] int_q;
  axis_e              axis_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [9:0]  fwd_s_q, lat_s_q;
  logic signed [15:0] yaw_s_q;
  logic               out_valid_q;
  logic signed [9:0]  out_fwd_q, out_lat_q;
  logic signed [15:0] out_yaw_q, out_vert_q;

  logic signed [16:0] err_c, prev_c;
  logic signed [15:0] integ_c, integ_new_c;
  logic signed [17:0] sum_c, der_c;
  logic signed [18:0] a_c;
  logic signed [17:0] b_c;
  logic signed [15:0] gp_c, gi_c, gd_c;
  logic signed [ACC_W-1:0] prod_ext, r12_c, r24_c, yaw_r_c;
  logic signed [9:0]  fwd_c, lat_c;
  logic signed [15:0] yaw_c, vert_c;
  logic               accept, push;

  assign accept = in_i.valid & ctrl_i.take;
  assign in_i.ready = ctrl_i.take;
  assign out_busy_o = out_valid_q & ~out_o.ready;
  assign push = ctrl_i.push & ~out_busy_o;

  always_comb begin
    unique case (ctrl_i.axis)
      AX_FWD: begin
        err_c = {z_q[15], z_q} - {cfg_i.desired_distance[15], cfg_i.desired_distance};
        prev_c = fwd_prev_q;
        integ_c = fwd_integ_q;
      end
      AX_LAT: begin
        err_c = {x_q[15], x_q} - {DESIRED_LATERAL[15], DESIRED_LATERAL};
        prev_c = lat_prev_q;
        integ_c = lat_integ_q;
      end
      AX_VERT: begin
        err_c = {cfg_i.desired_height[15], cfg_i.desired_height} - {y_q[15], y_q};
        prev_c = vert_prev_q;
        integ_c = vert_integ_q;
      end
      default: begin
        err_c = '0;
        prev_c = '0;
        integ_c = '0;
      end
    endcase
    sum_c = {{2{integ_c[15]}}, integ_c} + {err_c[16], err_c};
    der_c = {err_c[16], err_c} - {prev_c[16], prev_c};
    if (sum_c >= 18'(INTEG_LIM)) begin
      integ_new_c = INTEG_LIM;
    end else if (sum_c <= -18'(INTEG_LIM)) begin
      integ_new_c = -INTEG_LIM;
    end else begin
      integ_new_c = sum_c[15:0];
    end
  end

  always_comb begin
    if (axis_q == AX_VERT) begin
      gp_c = cfg_i.gain_vert_p;
      gi_c = cfg_i.gain_vert_i;
      gd_c = cfg_i.gain_vert_d;
    end else begin
      gp_c = cfg_i.gain_fwd_p;
      gi_c = cfg_i.gain_fwd_i;
      gd_c = cfg_i.gain_fwd_d;
    end
    unique case (ctrl_i.a_sel)
      A_ERR: a_c = {{2{err_q[16]}}, err_q};
      A_DER: a_c = {der_q[17], der_q};
      A_INT: a_c = {{3{int_q[15]}}, int_q};
      A_X: a_c = {{3{x_q[15]}}, x_q};
      A_ACC_LO: a_c = {1'b0, acc_q[17:0]};
      A_ACC_HI: a_c = acc_q[36:18];
      default: a_c = '0;
    endcase
    unique case (ctrl_i.b_sel)
      B_GP: b_c = {{2{gp_c[15]}}, gp_c};
      B_GI: b_c = {{2{gi_c[15]}}, gi_c};
      B_GD: b_c = {{2{gd_c[15]}}, gd_c};
      B_K3: b_c = K_POINT3;
      B_NK3: b_c = K_NEG3;
      default: b_c = '0;
    endcase
    prod_d = a_c * b_c;
  end

  always_comb begin
    prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    unique case (ctrl_i.acc_op)
      ACC_NOP: acc_d = acc_q;
      ACC_LOAD: acc_d = prod_ext;
      ACC_ADD: acc_d = acc_q + prod_ext;
      ACC_ADDSH: acc_d = acc_q + {prod_ext[ACC_W-19:0], 18'b0};
      default: acc_d = acc_q;
    endcase
  end

  always_comb begin
    r12_c = (acc_q + HALF_12) >>> 12;
    r24_c = (acc_q + HALF_24) >>> 24;
    yaw_r_c = (acc_q - YAW_OFF + HALF_12) >>> 12;
    if (r12_c > ACC_W'(VEL_LIM)) begin
      fwd_c = VEL_LIM;
    end else if (r12_c < -ACC_W'(VEL_LIM)) begin
      fwd_c = -VEL_LIM;
    end else begin
      fwd_c = r12_c[9:0];
    end
    if (r24_c > ACC_W'(VEL_LIM)) begin
      lat_c = VEL_LIM;
    end else if (r24_c < -ACC_W'(VEL_LIM)) begin
      lat_c = -VEL_LIM;
    end else begin
      lat_c = r24_c[9:0];
    end
    if (r12_c > ACC_W'(32767)) begin
      vert_c = 16'sh7fff;
    end else if (r12_c < -ACC_W'(32768)) begin
      vert_c = 16'sh8000;
    end else begin
      vert_c = r12_c[15:0];
    end
    if (yaw_r_c > ACC_W'(32767)) begin
      yaw_c = 16'sh7fff;
    end else if (yaw_r_c < -ACC_W'(32768)) begin
      yaw_c = 16'sh8000;
    end else begin
      yaw_c = yaw_r_c[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_integ_q <= '0;
      lat_integ_q <= '0;
      vert_integ_q <= '0;
      fwd_prev_q <= '0;
      lat_prev_q <= '0;
      vert_prev_q <= '0;
      axis_q <= AX_FWD;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.loop_en) begin
        axis_q <= ctrl_i.axis;
        unique case (ctrl_i.axis)
          AX_FWD: begin
            fwd_integ_q <= integ_new_c;
            fwd_prev_q <= err_c;
          end
          AX_LAT: begin
            lat_integ_q <= integ_new_c;
            lat_prev_q <= err_c;
          end
          AX_VERT: begin
            vert_integ_q <= integ_new_c;
            vert_prev_q <= err_c;
          end
          default: ;
        endcase
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= in_i.target_x;
      y_q <= in_i.target_y;
      z_q <= in_i.target_z;
    end
    if (ctrl_i.loop_en) begin
      err_q <= err_c;
      der_q <= der_c;
      int_q <= integ_new_c;
    end
    prod_q <= prod_d;
    acc_q <= acc_d;
    unique case (ctrl_i.wb)
      WB_NONE: ;
      WB_FWD: fwd_s_q <= fwd_c;
      WB_YAW: yaw_s_q <= yaw_c;
      WB_LAT: lat_s_q <= lat_c;
      default: ;
    endcase
    if (push) begin
      out_fwd_q <= fwd_s_q;
      out_yaw_q <= yaw_s_q;
      out_lat_q <= lat_s_q;
      out_vert_q <= vert_c;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.forward_vel = out_fwd_q;
  assign out_o.yaw_rate = out_yaw_q;
  assign out_o.vertical_vel = out_vert_q;
  assign out_o.lateral_vel = out_lat_q;

endmodule
